// ===== hdl/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg: shared types and constants of the stack pop sequence checker
// Register indexes, field widths, queue sizing and the queue word format.
// ----------------------------------------------------------------------------
`default_nettype none

package spsc_pkg;

    // Width of a pop value and of each configuration register
    localparam int VAL_W = 11;
    localparam int CFG_W = 11;
    // next push value can reach seq_length + 1
    localparam int NP_W  = VAL_W + 1;

    // Stream data widths in bits
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Default stack storage depth
    localparam int SPSC_MAX_DEPTH = 1024;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_STACK_CAPACITY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEQ_LENGTH     = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] STACK_CAPACITY_RST = CFG_W'(1024);
    localparam logic [CFG_W-1:0] SEQ_LENGTH_RST     = CFG_W'(1024);

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One classified word in the queue
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             bad;    // zero or above sequence length
    } spsc_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        spsc_item_t item;
    } spsc_head_t;

endpackage

`default_nettype wire

// ===== hdl/stack_pop_sequence_checker.sv =====
// ----------------------------------------------------------------------------
// stack_pop_sequence_checker: stack pop order validator
// Checks a stream of pop values against pushes of 1..n onto a bounded stack.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one pop value per word in s_tdata[10:0]. Each word is
//   checked against a stack onto which 1, 2, ... n are pushed in order.
//   m_ channel: after the n-th word of a sequence one word comes out with
//   the verdict in m_tdata[0]: 1 for a legal pop order, 0 otherwise. The
//   sequence state then clears for the next sequence.
//   Config port: cfg_wr_en/cfg_addr/cfg_wr_data write stack_capacity
//   (index 0) and seq_length (index 1); write only while the block is idle.
// Flow:
//   A four-word queue decouples the input from the stack engine. For each
//   word the engine pushes the values still due, the last of which cancels
//   against its pop, or else reads the stack top through its registered
//   read port and compares it. Every value is pushed once. Out-of-range
//   words and words after a failure are settled without a push or a stack
//   read. The verdict is registered and raised on m_tvalid once the last
//   word of its sequence is settled.
// Reset and stall:
//   Reset empties the queue, clears the stack and restores both registers
//   to 1024. While a verdict waits on m_tready the engine holds the last
//   word of the next sequence; the queue keeps taking words until full.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_pop_sequence_checker
    import spsc_pkg::*;
#(
    parameter int MAX_DEPTH = SPSC_MAX_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,     // [10:0] pop_value
    // Result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,     // [0] verdict
    // Configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wr_data
);

    logic [CFG_W-1:0] stack_capacity_reg;
    logic [CFG_W-1:0] seq_length_reg;
    spsc_head_t       head;
    logic             head_pop;

    // Configuration registers: take the write on the enable edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_capacity_reg <= STACK_CAPACITY_RST;
            seq_length_reg     <= SEQ_LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STACK_CAPACITY: stack_capacity_reg <= cfg_wr_data;
                REG_SEQ_LENGTH:     seq_length_reg     <= cfg_wr_data;
                default:            ;
            endcase
        end
    end

    // Front: accept, flag out-of-range values, queue
    spsc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .seq_length (seq_length_reg),
        .head       (head),
        .head_pop   (head_pop)
    );

    // Back: push, compare top, pop, emit verdict
    spsc_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .head_pop       (head_pop),
        .stack_capacity (stack_capacity_reg),
        .seq_length     (seq_length_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/spsc_front.sv =====
// ----------------------------------------------------------------------------
// spsc_front: ingest and classify pop values
// Accepts input words, flags out-of-range values and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_front
    import spsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,    // [10:0] pop_value
    input  wire logic [CFG_W-1:0]     seq_length,
    output spsc_head_t                head,
    input  wire logic                 head_pop
);

    spsc_item_t       q_mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             push, pop;
    spsc_item_t       in_item;

    always_comb begin
        in_item.value = s_tdata[VAL_W-1:0];
        in_item.bad   = (in_item.value == '0) || (in_item.value > seq_length);
    end

    assign s_tready   = (count_reg != QCW'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];
    assign pop        = head_pop && head.valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload: no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/spsc_back.sv =====
// ----------------------------------------------------------------------------
// spsc_back: stack engine
// Pushes one value per cycle, checks the stack top and issues the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_back
    import spsc_pkg::*;
#(
    parameter int MAX_DEPTH = SPSC_MAX_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire spsc_head_t           head,
    output logic                      head_pop,
    input  wire logic [CFG_W-1:0]     stack_capacity,
    input  wire logic [CFG_W-1:0]     seq_length,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata     // [0] verdict
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int FW = $clog2(MAX_DEPTH + 1);
    localparam int DW = (FW > CFG_W) ? FW : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [NP_W-1:0]  np_reg, np_next;
    logic [CFG_W-1:0] seen_reg, seen_next;
    logic             failed_reg, failed_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             out_valid_reg, out_valid_next;
    logic             verdict_reg, verdict_next;

    logic [VAL_W-1:0] stack_mem [MAX_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic [DW-1:0]    eff_depth;
    logic             stack_full;
    logic             is_last;
    logic             finish;
    logic             fail_now;
    logic [FW-1:0]    fill_dec;

    always_comb begin
        eff_depth = (DW'(stack_capacity) < DW'(MAX_DEPTH)) ? DW'(stack_capacity)
                                                           : DW'(MAX_DEPTH);
        stack_full = (DW'(fill_reg) >= eff_depth);
        is_last    = ((CFG_W + 1)'(seen_reg) + 1'b1) >= (CFG_W + 1)'(seq_length);
        fill_dec   = fill_reg - 1'b1;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        np_next        = np_reg;
        seen_next      = seen_reg;
        failed_next    = failed_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !m_tready;
        verdict_next   = verdict_reg;
        head_pop       = 1'b0;
        finish         = 1'b0;
        fail_now       = failed_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[AW-1:0];
        mem_wdata      = np_reg[VAL_W-1:0];
        mem_re         = 1'b0;
        mem_raddr      = fill_dec[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                // hold the last word of a sequence while a verdict still waits
                if (head.valid && !(is_last && out_valid_reg)) begin
                    head_pop = 1'b1;
                    val_next = head.item.value;
                    if (failed_reg || head.item.bad) begin
                        fail_now = 1'b1;
                        finish   = 1'b1;
                    end else if (np_reg <= {1'b0, head.item.value}) begin
                        state_next = ST_PUSH;
                    end else if (fill_reg == '0) begin
                        fail_now = 1'b1;
                        finish   = 1'b1;
                    end else begin
                        mem_re     = 1'b1;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_PUSH: begin
                if (stack_full) begin
                    fail_now   = 1'b1;
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    np_next = np_reg + 1'b1;
                    if (np_reg == {1'b0, val_reg}) begin
                        // push of the value itself cancels against its pop
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_CMP: begin
                finish     = 1'b1;
                state_next = ST_IDLE;
                if (rd_data_reg == val_reg) begin
                    fill_next = fill_dec;
                end else begin
                    fail_now = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            if (is_last) begin
                out_valid_next = 1'b1;
                verdict_next   = !fail_now;
                fill_next      = '0;
                np_next        = NP_W'(1);
                seen_next      = '0;
                failed_next    = 1'b0;
            end else begin
                seen_next   = seen_reg + 1'b1;
                failed_next = fail_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            np_reg        <= NP_W'(1);
            seen_reg      <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            np_reg        <= np_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        verdict_reg <= verdict_next;
    end

    // Stack storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, verdict_reg};

endmodule

`default_nettype wire

// ===== tb/stack_pop_sequence_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_pop_sequence_checker_tb: self-checking bench for the pop order checker
// Streams claimed pop sequences (legal, corrupted and noise) into the block
// under many capacity and length settings. It predicts each verdict with an
// in-bench stack model and checks every result word against that prediction.
// ----------------------------------------------------------------------------

module stack_pop_sequence_checker_tb;
    import spsc_pkg::*;

    // Clock, reset and block ports; every input starts at a known value
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;    // [10:0] pop_value
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;             // [0] verdict
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    stack_pop_sequence_checker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // Pop values waiting to be offered, and verdicts predicted but not yet seen
    logic [VAL_W-1:0] pop_words[$];
    logic             verdicts_due[$];
    int               mismatch_count = 0;

    // ------------------------------------------------------------------------
    // Stack model: its own copy of the registers and of the sequence state
    // ------------------------------------------------------------------------
    int               capacity_reg = 1024;
    int               length_reg   = 1024;
    logic [VAL_W-1:0] stack_mem [SPSC_MAX_DEPTH];
    int               stack_fill   = 0;
    int               next_push    = 1;
    int               items_in_seq = 0;
    logic             seq_failed   = 1'b0;

    // Apply one accepted pop value; queue a verdict when the sequence closes
    task automatic step_pop_check(input logic [VAL_W-1:0] value);
        int depth;
        depth = (capacity_reg < SPSC_MAX_DEPTH) ? capacity_reg : SPSC_MAX_DEPTH;
        if (!seq_failed) begin
            if (value == 0 || int'(value) > length_reg) begin
                seq_failed = 1'b1;
            end else begin
                // push every value up to and including the one being popped
                while (!seq_failed && next_push <= int'(value)) begin
                    if (stack_fill >= depth) begin
                        seq_failed = 1'b1;
                    end else begin
                        stack_mem[stack_fill] = VAL_W'(next_push);
                        stack_fill++;
                        next_push++;
                    end
                end
                if (!seq_failed) begin
                    if (stack_fill == 0 || stack_mem[stack_fill-1] != value)
                        seq_failed = 1'b1;
                    else
                        stack_fill--;
                end
            end
        end
        // a failed sequence only counts its remaining words
        items_in_seq++;
        if (items_in_seq >= length_reg) begin
            verdicts_due.push_back(!seq_failed);
            stack_fill   = 0;
            next_push    = 1;
            items_in_seq = 0;
            seq_failed   = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer pending words, hold while stalled, random gaps per word
    // ------------------------------------------------------------------------
    int   tx_wait  = 0;
    logic tx_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                step_pop_check(s_tdata[VAL_W-1:0]);
            if (s_tvalid && !s_tready) begin
                // hold the word until the block takes it
            end else if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end else if (pop_words.size() > 0) begin
                s_tdata  <= {{(S_TDATA_W-VAL_W){1'b0}}, pop_words.pop_front()};
                s_tvalid <= 1'b1;
                tx_wait  = tx_burst ? 0 : $urandom_range(0, 6);
                // switch between gappy and back-to-back stretches now and then
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each verdict word, stall at random, long hold on request
    // ------------------------------------------------------------------------
    int   rx_wait       = 0;
    logic rx_burst      = 1'b0;
    int   hold_left     = 0;
    int   holds_asked   = 0;
    int   holds_started = 0;
    logic want_verdict;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("verdict %0b with none expected", m_tdata[0]));
                end else begin
                    want_verdict = verdicts_due.pop_front();
                    if (m_tdata[0] !== want_verdict)
                        report_mismatch($sformatf("verdict %0b, expected %0b",
                                                  m_tdata[0], want_verdict));
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_started != holds_asked) begin
                // long hold: let the block back up and stall its input
                holds_started++;
                hold_left = 300;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Wait until every word is taken and every verdict is in, then let the
    // engine drain for the given tail. Sample on the falling edge so the
    // driver and monitor have settled.
    task automatic wait_idle(input int tail_cycles);
        do @(negedge aclk);
        while (pop_words.size() != 0 || s_tvalid || verdicts_due.size() != 0);
        repeat (tail_cycles) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input int value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= index;
        cfg_wr_data <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (index == REG_STACK_CAPACITY)
            capacity_reg = value & 32'h7FF;
        else
            length_reg = value & 32'h7FF;
    endtask

    task automatic queue4(input int a, input int b, input int c, input int d);
        pop_words.push_back(VAL_W'(a));
        pop_words.push_back(VAL_W'(b));
        pop_words.push_back(VAL_W'(c));
        pop_words.push_back(VAL_W'(d));
    endtask

    // Build one sequence of n words: a legal pop order from a random walk over
    // a stack of roughly the given capacity, then optionally corrupted.
    localparam int SEQ_LEGAL = 0;
    localparam int SEQ_SWAP  = 1;
    localparam int SEQ_WILD  = 2;
    localparam int SEQ_DUP   = 3;
    localparam int SEQ_NOISE = 4;

    task automatic queue_sequence(input int n, input int cap, input int kind);
        logic [VAL_W-1:0] seq[$];
        logic [VAL_W-1:0] held[$];
        logic [VAL_W-1:0] tmp;
        int               nxt;
        int               room;
        int               i;
        int               j;
        room = (cap < 1) ? 1 : cap;
        // one slot too many now and then, so the walk overflows the block
        if ($urandom_range(0, 7) == 0)
            room++;
        nxt = 1;
        while (seq.size() < n) begin
            if (nxt <= n && held.size() < room &&
                (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
                held.push_back(VAL_W'(nxt));
                nxt++;
            end else begin
                seq.push_back(held.pop_back());
            end
        end
        i = $urandom_range(0, n - 1);
        j = $urandom_range(0, n - 1);
        case (kind)
            SEQ_SWAP: begin
                tmp    = seq[i];
                seq[i] = seq[j];
                seq[j] = tmp;
            end
            SEQ_WILD: begin
                seq[i] = VAL_W'($urandom_range(0, 2047));
            end
            SEQ_DUP: begin
                if (n > 1) begin
                    i = $urandom_range(1, n - 1);
                    seq[i] = seq[$urandom_range(0, i - 1)];
                end
            end
            SEQ_NOISE: begin
                foreach (seq[k])
                    seq[k] = ($urandom_range(0, 1) == 1) ?
                             VAL_W'($urandom_range(0, n + 1)) :
                             VAL_W'($urandom_range(0, 2047));
            end
            default: begin
            end
        endcase
        foreach (seq[k])
            pop_words.push_back(seq[k]);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        int random_items;
        int phase_items;
        int len;
        int cap;
        int pick;
        int kind;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: length 1024, capacity 1024. Push all, pop all: the
        // stack fills to exactly its full depth and the order is legal.
        for (int v = 1024; v >= 1; v--)
            pop_words.push_back(VAL_W'(v));
        wait_idle(12);

        // Directed cases on four-word sequences
        write_reg(REG_STACK_CAPACITY, 4);
        write_reg(REG_SEQ_LENGTH, 4);
        queue4(1, 2, 3, 4);          // push and pop at once
        queue4(4, 3, 2, 1);          // stack exactly full
        queue4(3, 1, 2, 4);          // 1 is buried under 2
        queue4(0, 1, 2, 3);          // zero value
        queue4(2047, 1, 2, 3);       // value above the length
        queue4(2, 2, 3, 4);          // repeated value
        wait_idle(12);
        write_reg(REG_STACK_CAPACITY, 2);
        queue4(4, 3, 2, 1);          // push into a full stack
        wait_idle(12);
        write_reg(REG_STACK_CAPACITY, 0);
        write_reg(REG_SEQ_LENGTH, 2);
        pop_words.push_back(VAL_W'(1));   // no push can ever succeed
        pop_words.push_back(VAL_W'(2));
        wait_idle(12);
        write_reg(REG_SEQ_LENGTH, 0);
        pop_words.push_back(VAL_W'(1));   // every word closes its own sequence
        pop_words.push_back(VAL_W'(1024));
        wait_idle(12);

        // One verdict per word while the receiver holds off, so the block
        // fills and stalls; then pause the sender until all verdicts are in.
        write_reg(REG_STACK_CAPACITY, 3);
        write_reg(REG_SEQ_LENGTH, 1);
        holds_asked++;
        for (int k = 0; k < 40; k++)
            pop_words.push_back(($urandom_range(0, 3) == 0) ?
                                VAL_W'($urandom_range(0, 2047)) : VAL_W'(1));
        wait_idle(0);
        for (int k = 0; k < 20; k++)
            pop_words.push_back(VAL_W'($urandom_range(0, 2)));
        wait_idle(12);

        // Random phases: mostly short sequences, mostly well formed
        random_items = 0;
        while (random_items < 840) begin
            pick = $urandom_range(0, 11);
            len  = (pick == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            case (pick)
                1:       cap = 2047;
                2:       cap = 1024;
                3:       cap = 1;
                4:       cap = 0;
                default: cap = $urandom_range(1, len);
            endcase
            write_reg(REG_STACK_CAPACITY, cap);
            write_reg(REG_SEQ_LENGTH, len);
            phase_items = 0;
            while (phase_items < 60) begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                    kind = SEQ_LEGAL;
                else
                    kind = kind - 5;
                queue_sequence(len, cap, kind);
                phase_items += len;
                // sender pause mid-phase now and then
                if ($urandom_range(0, 15) == 0)
                    wait_idle(0);
            end
            random_items += phase_items;
            wait_idle(12);
        end

        // Let any stray word show up before the verdict
        wait_idle(40);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(64'd5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
